// ===== sv/rmst_pkg.sv =====
package rmst_pkg;

    // fixed field widths
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    // default tree size, a power of two
    localparam int LEAVES_DEFAULT = 1024;

    // value every node takes at reset, and reset value of the identity register
    localparam logic signed [DATA_W-1:0] IDENTITY_RESET = -32'sd10000;

    // request codes
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

endpackage

// ===== sv/rmst_if.sv =====
interface rmst_req_if import rmst_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         leaf_index;
    logic signed [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]         range_low;
    logic [IDX_W-1:0]         range_high;

    modport source (
        output valid, req_type, leaf_index, new_value, range_low, range_high,
        input  ready
    );

    modport sink (
        input  valid, req_type, leaf_index, new_value, range_low, range_high,
        output ready
    );

endinterface

interface rmst_rsp_if import rmst_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_max;

    modport source (
        output valid, range_max,
        input  ready
    );

    modport sink (
        input  valid, range_max,
        output ready
    );

endinterface

// ===== sv/range_max_segment_tree_top.sv =====
// Range-maximum segment tree over LEAVES signed 32-bit values, held in a
// single 2*LEAVES-word memory (node 1 is the root, leaf k is node LEAVES+k).
// After reset a clearing pass writes the reset value into every node, one per
// cycle, so no request item is taken until the pass is done; writes to
// the identity register are taken at any time. An update item writes the
// leaf, then climbs to the root, setting each parent to the max of its pair,
// and gives no result. A query item climbs from both range ends, taking the
// left end then the right end at each level, and gives one result. The
// steps are set by the memory's single read port, whose data is registered,
// and by the one signed max comparator that all steps share. Items are worked
// one at a time; a finished result waits in an output register while the
// next item is taken. Indexes are reduced modulo LEAVES and a query with
// range_low above range_high returns the identity value.
module range_max_segment_tree_top
    import rmst_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic signed [DATA_W-1:0] cfg_wdata,
    rmst_req_if.sink                 req,
    rmst_rsp_if.source               rsp
);

    localparam int LEAF_W    = $clog2(LEAVES);
    localparam int NODE_W    = LEAF_W + 1;
    localparam int PTR_W     = NODE_W + 1;
    localparam int IDX_EXT_W = (LEAF_W > IDX_W) ? LEAF_W : IDX_W;
    localparam int DEPTH     = 2 * LEAVES;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_UPD   = 4'b0100,
        ST_QRY   = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [NODE_W-1:0]        clr_reg, clr_next;
    logic [NODE_W-1:0]        node_reg, node_next;
    logic [PTR_W-1:0]         lo_reg, lo_next;
    logic [PTR_W-1:0]         hi_reg, hi_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic                     phase_reg, phase_next;
    logic                     pend_reg, pend_next;
    logic signed [DATA_W-1:0] ident_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_load;

    // node memory
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic                     mem_we;
    logic [NODE_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [NODE_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] rdata_reg;

    // index reduction modulo LEAVES
    logic [IDX_EXT_W-1:0]     leaf_ext, low_ext, high_ext;
    logic [LEAF_W-1:0]        leaf, low, high;
    logic [NODE_W-1:0]        leaf_node;
    logic [NODE_W-1:0]        parent;

    // shared max unit
    logic signed [DATA_W-1:0] max_out;
    logic signed [DATA_W-1:0] acc_fold;
    logic                     range_done;
    logic                     out_free;

    assign leaf_ext  = IDX_EXT_W'(req.leaf_index);
    assign low_ext   = IDX_EXT_W'(req.range_low);
    assign high_ext  = IDX_EXT_W'(req.range_high);
    assign leaf      = leaf_ext[LEAF_W-1:0];
    assign low       = low_ext[LEAF_W-1:0];
    assign high      = high_ext[LEAF_W-1:0];
    assign leaf_node = {1'b1, leaf};
    assign parent    = node_reg >> 1;

    assign max_out    = (rdata_reg > acc_reg) ? rdata_reg : acc_reg;
    assign acc_fold   = pend_reg ? max_out : acc_reg;
    assign range_done = lo_reg > hi_reg;
    assign out_free   = !out_valid_reg || rsp.ready;

    // handshake outputs
    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.range_max = out_data_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        node_next  = node_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = IDENTITY_RESET;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == {NODE_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_UPDATE)
                    begin
                        // write the leaf and fetch its sibling
                        mem_we     = 1'b1;
                        mem_waddr  = leaf_node;
                        mem_wdata  = req.new_value;
                        mem_re     = 1'b1;
                        mem_raddr  = leaf_node ^ NODE_W'(1);
                        acc_next   = req.new_value;
                        node_next  = leaf_node;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        lo_next    = {2'b01, low};
                        hi_next    = {2'b01, high};
                        acc_next   = ident_reg;
                        phase_next = 1'b0;
                        pend_next  = 1'b0;
                        state_next = ST_QRY;
                    end
                end
            end
            ST_UPD:
            begin
                // parent takes the max of the pair, then fetch its sibling unless it is the root
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = max_out;
                acc_next  = max_out;
                node_next = parent;
                if (parent == NODE_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent ^ NODE_W'(1);
                end
            end
            ST_QRY:
            begin
                // fold the node read in the previous cycle
                acc_next  = acc_fold;
                pend_next = 1'b0;
                if (!phase_reg)
                begin
                    if (range_done)
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // left end is a right child: take it and step in
                        if (lo_reg[0])
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = lo_reg[NODE_W-1:0];
                            pend_next = 1'b1;
                            lo_next   = lo_reg + PTR_W'(1);
                        end
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    // right end is a left child: take it and step in
                    if (!hi_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = hi_reg[NODE_W-1:0];
                        pend_next = 1'b1;
                        hi_next   = (hi_reg - PTR_W'(1)) >> 1;
                    end
                    else
                    begin
                        hi_next = hi_reg >> 1;
                    end
                    lo_next    = lo_reg >> 1;
                    phase_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            phase_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ident_reg     <= IDENTITY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            if (cfg_we)
            begin
                ident_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        acc_reg  <= acc_next;
        if (out_load)
        begin
            out_data_reg <= acc_fold;
        end
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // an accepted update starts the climb to the root
    a_upd_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_UPDATE) |=> (state_reg == ST_UPD))
        else $error("update item did not start the climb");

    // while climbing, the current node is always below the root
    a_upd_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (node_reg > NODE_W'(1)))
        else $error("update node left the tree");

    // the left query pointer never runs past the tree
    a_lo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QRY) |-> (lo_reg <= PTR_W'(DEPTH)))
        else $error("query pointer out of range");

    // a pending node read only exists inside a query
    a_pend_qry: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_QRY))
        else $error("pending read outside a query");

endmodule

// ===== verif/testbench.sv =====
module testbench import rmst_pkg::*; ();

    localparam int LEAVES        = LEAVES_DEFAULT;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_ITEMS  = 1725;
    localparam int RANDOM_PHASES = 5;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         leaf_index;
        logic signed [DATA_W-1:0] new_value;
        logic [IDX_W-1:0]         range_low;
        logic [IDX_W-1:0]         range_high;
    } req_item_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic signed [DATA_W-1:0] cfg_wdata;

    rmst_req_if req_if ();
    rmst_rsp_if rsp_if ();

    range_max_segment_tree_top #(
        .LEAVES (LEAVES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // shadow of the leaf values and the identity register
    logic signed [DATA_W-1:0] leaf_vals [LEAVES];
    logic signed [DATA_W-1:0] model_identity;
    logic signed [DATA_W-1:0] expected_max_q [$];

    int errors      = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int cluster_base = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        model_identity = IDENTITY_RESET;
        for (int k = 0; k < LEAVES; k++)
            leaf_vals[k] = IDENTITY_RESET;
    end

    // max over the inclusive leaf range, starting from the identity value
    function automatic logic signed [DATA_W-1:0] range_max_of(input int lo, input int hi);
        logic signed [DATA_W-1:0] acc;
        acc = model_identity;
        for (int k = lo; k <= hi; k++)
            if (leaf_vals[k] > acc)
                acc = leaf_vals[k];
        return acc;
    endfunction

    // apply one accepted item to the shadow tree
    function automatic void apply_to_tree_model(input req_item_t it);
        int lo;
        int hi;
        if (it.req_type == REQ_UPDATE)
        begin
            leaf_vals[int'(it.leaf_index) % LEAVES] = it.new_value;
        end
        else
        begin
            lo = int'(it.range_low) % LEAVES;
            hi = int'(it.range_high) % LEAVES;
            expected_max_q.push_back(range_max_of(lo, hi));
        end
    endfunction

    // item builders, unused fields carry random noise
    function automatic req_item_t mk_update(input int idx, input logic signed [DATA_W-1:0] v);
        req_item_t it;
        it.req_type   = REQ_UPDATE;
        it.leaf_index = IDX_W'(idx);
        it.new_value  = v;
        it.range_low  = IDX_W'($urandom_range(LEAVES-1));
        it.range_high = IDX_W'($urandom_range(LEAVES-1));
        return it;
    endfunction

    function automatic req_item_t mk_query(input int lo, input int hi);
        req_item_t it;
        it.req_type   = REQ_QUERY;
        it.leaf_index = IDX_W'($urandom_range(LEAVES-1));
        it.new_value  = $urandom;
        it.range_low  = IDX_W'(lo);
        it.range_high = IDX_W'(hi);
        return it;
    endfunction

    // observe handshakes, predict and check
    always @(posedge clk)
    begin
        req_item_t it;
        logic signed [DATA_W-1:0] want;
        if (rst_n !== 1'b1)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (cfg_we)
            begin
                model_identity = cfg_wdata;
                idle_cycles    = 0;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                idle_cycles = 0;
                if (expected_max_q.size() == 0)
                begin
                    $display("%0t: result with none expected, actual range_max=%0d",
                             $time, rsp_if.range_max);
                    errors++;
                end
                else
                begin
                    want = expected_max_q.pop_front();
                    if (rsp_if.range_max !== want)
                    begin
                        $display("%0t: range_max mismatch, expected %0d actual %0d",
                                 $time, want, rsp_if.range_max);
                        errors++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                idle_cycles   = 0;
                it.req_type   = req_if.req_type;
                it.leaf_index = req_if.leaf_index;
                it.new_value  = req_if.new_value;
                it.range_low  = req_if.range_low;
                it.range_high = req_if.range_high;
                apply_to_tree_model(it);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL range_max_segment_tree_top");
        $finish;
    end

    // result side stalls, mode picked anew at the end of each random-length phase
    initial
    begin
        int mode;
        int phase_left;
        int stall_left;
        rsp_if.ready <= 1'b0;
        mode       = 0;
        phase_left = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                mode       = $urandom_range(3);
                phase_left = $urandom_range(300, 50);
            end
            phase_left--;
            case (mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= ($urandom_range(1) == 1);
                2:
                begin
                    // occasional long stall
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rsp_if.ready <= 1'b0;
                    end
                    else if ($urandom_range(15) == 0)
                    begin
                        stall_left = $urandom_range(30, 5);
                        rsp_if.ready <= 1'b0;
                    end
                    else
                    begin
                        rsp_if.ready <= 1'b1;
                    end
                end
                default: rsp_if.ready <= ((phase_left % 4) != 0);
            endcase
        end
    end

    // send one item, in bursts with gaps between them
    task automatic send_req(input req_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(15, 1);
            if ($urandom_range(4) == 0)
                burst_left = $urandom_range(300, 100);
            else
                burst_left = $urandom_range(20, 1);
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= it.req_type;
        req_if.leaf_index <= it.leaf_index;
        req_if.new_value  <= it.new_value;
        req_if.range_low  <= it.range_low;
        req_if.range_high <= it.range_high;
        burst_left--;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // stop sending and wait for all results, then let the block settle
    task automatic wait_idle(input int settle);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_max_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_identity(input logic signed [DATA_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // queries on the cleared tree with the reset identity
    task automatic test_cleared_tree();
        send_req(mk_query(0, LEAVES-1));
        send_req(mk_query(5, 5));
        send_req(mk_query(LEAVES-1, LEAVES-1));
        wait_idle(SETTLE_CYCLES);
    endtask

    // field extremes, lowering a leaf, identity write leaves nodes alone
    task automatic test_extremes();
        write_identity(VAL_MIN);
        send_req(mk_query(0, LEAVES-1));
        send_req(mk_update(0, VAL_MAX));
        send_req(mk_update(LEAVES-1, VAL_MIN));
        send_req(mk_update(LEAVES/2, -1));
        send_req(mk_query(0, 0));
        send_req(mk_query(LEAVES-1, LEAVES-1));
        send_req(mk_query(1, LEAVES-1));
        send_req(mk_query(0, LEAVES-1));
        send_req(mk_update(0, 0));
        send_req(mk_query(0, LEAVES-1));
        send_req(mk_query(1, 1));
        wait_idle(SETTLE_CYCLES);
    endtask

    // low above high gives the identity value
    task automatic test_empty_range();
        send_req(mk_query(LEAVES-1, 0));
        send_req(mk_query(LEAVES/2 + 1, LEAVES/2));
        send_req(mk_query(1, 0));
        wait_idle(SETTLE_CYCLES);
    endtask

    // queries under several identity values
    task automatic test_identity_settings();
        logic signed [DATA_W-1:0] ids [3];
        ids[0] = VAL_MAX;
        ids[1] = 0;
        ids[2] = $urandom;
        for (int s = 0; s < 3; s++)
        begin
            write_identity(ids[s]);
            send_req(mk_query(0, LEAVES-1));
            send_req(mk_query(LEAVES-1, 1));
            send_req(mk_query(2, LEAVES/2 + 3));
            wait_idle(SETTLE_CYCLES);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return $urandom;
        else if (r < 8)
            return $urandom_range(200) - 100;
        else if (r == 8)
            return ($urandom_range(1) == 1) ? VAL_MAX : VAL_MIN;
        else
            return IDENTITY_RESET + $urandom_range(4) - 2;
    endfunction

    function automatic req_item_t rand_req();
        int r;
        int lo;
        int hi;
        if ($urandom_range(99) < 45)
        begin
            if ($urandom_range(9) < 6)
                return mk_update(cluster_base + $urandom_range(15), rand_value());
            else
                return mk_update($urandom_range(LEAVES-1), rand_value());
        end
        r = $urandom_range(99);
        if (r < 30)
        begin
            // narrow range around the busy leaves
            lo = cluster_base + $urandom_range(7);
            hi = lo + $urandom_range(8);
        end
        else if (r < 45)
        begin
            lo = $urandom_range(LEAVES-1);
            hi = lo;
        end
        else if (r < 55)
        begin
            hi = $urandom_range(LEAVES-2);
            lo = hi + 1 + $urandom_range(LEAVES-2-hi);
        end
        else if (r < 65)
        begin
            lo = $urandom_range(3);
            hi = LEAVES - 1 - $urandom_range(3);
        end
        else
        begin
            lo = $urandom_range(LEAVES-1);
            hi = $urandom_range(LEAVES-1);
        end
        return mk_query(lo, hi);
    endfunction

    // random traffic in phases, identity changed between phases
    task automatic test_random_traffic();
        logic signed [DATA_W-1:0] id;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                1: id = $urandom_range(60) - 30;
                2: id = VAL_MIN;
                3: id = IDENTITY_RESET;
                default: id = $urandom;
            endcase
            write_identity(id);
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                if ((n % 64) == 0)
                    cluster_base = $urandom_range(LEAVES - 16);
                // hold off until every pending result is back
                if ($urandom_range(149) == 0)
                    wait_idle(0);
                send_req(rand_req());
            end
            wait_idle(SETTLE_CYCLES);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_UPDATE;
        req_if.leaf_index <= '0;
        req_if.new_value  <= '0;
        req_if.range_low  <= '0;
        req_if.range_high <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_tree();
        test_extremes();
        test_empty_range();
        test_identity_settings();
        test_random_traffic();

        wait_idle(SETTLE_CYCLES);
        if (expected_max_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_max_q.size());
        if (errors == 0 && expected_max_q.size() == 0)
            $display("PASS range_max_segment_tree_top");
        else
            $display("FAIL range_max_segment_tree_top");
        $finish;
    end

endmodule

// ===== range_max_segment_tree_top.f =====
sv/rmst_pkg.sv
sv/rmst_if.sv
sv/range_max_segment_tree_top.sv
verif/testbench.sv
